/* src/tlik_pkg.sv */
package tlik_pkg;

   localparam int CORDIC_STEPS_DEF = 16;

   localparam int LEN_W      = 15;
   localparam int OFF_W      = 17;
   localparam int COORD_W    = 16;
   localparam int JOINT_W    = 16;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // wrist point and squared terms
   localparam int NXY_W  = 18;
   localparam int SQ_W   = 32;
   localparam int DIF2_W = 30;
   localparam int C2_W   = 33;
   localparam int N_W    = 35;
   localparam int SCALE  = 20;

   // digit-by-digit square root, two radicand bits per cell
   localparam int SQRT_STEPS = 27;
   localparam int SQRT_VAL_W = 2 * SQRT_STEPS;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int S_W        = 2 * ROOT_W;

   // CORDIC datapath, angles in 2^32 per turn
   localparam int CX_W  = 56;
   localparam int Z_W   = 34;
   localparam int ANG_W = 36;

   localparam logic signed [Z_W-1:0]   Z_QUARTER   = Z_W'(64'h40000000);
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'h40000000);
   localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(64'h80000000);
   localparam int CENTI_TURN = 36000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_UPPER_ARM  = 3'd0,
      REG_FOREARM    = 3'd1,
      REG_GRIPPER    = 3'd2,
      REG_BASE       = 3'd3,
      REG_SHOULDER   = 3'd4,
      REG_ELBOW      = 3'd5,
      REG_WRIST      = 3'd6
   } csr_idx_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_REACH    = 2'd1,
      STAT_SHOULDER = 2'd2
   } status_type;

   typedef struct packed {
      logic [SQRT_VAL_W-1:0] val;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } sqrt_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   typedef struct packed {
      logic                    kind;
      status_type              status;
      logic signed [NXY_W-1:0] nx;
      logic signed [NXY_W-1:0] ny;
      logic signed [N_W-1:0]   n1;
      logic signed [N_W-1:0]   nb;
   } side_front_type;

   typedef struct packed {
      logic       kind;
      status_type status;
   } side_back_type;

   typedef struct packed {
      logic [JOINT_W-1:0] shoulder_angle;
      logic [JOINT_W-1:0] elbow_angle;
      logic [JOINT_W-1:0] wrist_angle;
      logic [STAT_W-1:0]  status;
   } rsp_word_type;

   function automatic logic [31:0] atan_tab(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
         12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
         18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
         21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
         24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
         27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

/* src/tlik_if.sv */
interface tlik_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [tlik_pkg::COORD_W-1:0]  target_x;
   logic signed [tlik_pkg::COORD_W-1:0]  target_y;

   modport source (output valid, kind, target_x, target_y, input ready);
   modport sink   (input valid, kind, target_x, target_y, output ready);
endinterface

interface tlik_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tlik_pkg::JOINT_W-1:0]  shoulder_angle;
   logic [tlik_pkg::JOINT_W-1:0]  elbow_angle;
   logic [tlik_pkg::JOINT_W-1:0]  wrist_angle;
   logic [tlik_pkg::STAT_W-1:0]   status;

   modport source (output valid, shoulder_angle, elbow_angle, wrist_angle, status,
                   input ready);
   modport sink   (input valid, shoulder_angle, elbow_angle, wrist_angle, status,
                   output ready);
endinterface

/* src/tlik_sqrt_cell.sv */
module tlik_sqrt_cell (
   input  logic                clock,
   input  logic                en,
   input  tlik_pkg::sqrt_type  cell_in,
   output tlik_pkg::sqrt_type  cell_out
);

   localparam int RT_W = tlik_pkg::REM_W + 2;
   localparam int VW   = tlik_pkg::SQRT_VAL_W;

   tlik_pkg::sqrt_type cell_ff, cell_in_w;
   logic [RT_W-1:0] rem_t, trial;

   always_comb begin
      rem_t = {cell_in.rem, cell_in.val[VW-1 -: 2]};
      trial = RT_W'({cell_in.root, 2'b01});
      cell_in_w.val = {cell_in.val[VW-3:0], 2'b00};
      if (rem_t >= trial) begin
         cell_in_w.rem  = tlik_pkg::REM_W'(rem_t - trial);
         cell_in_w.root = {cell_in.root[tlik_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         cell_in_w.rem  = tlik_pkg::REM_W'(rem_t);
         cell_in_w.root = {cell_in.root[tlik_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* src/tlik_cordic_cell.sv */
module tlik_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  tlik_pkg::cordic_type  cell_in,
   output tlik_pkg::cordic_type  cell_out
);

   localparam logic signed [tlik_pkg::Z_W-1:0] ATAN =
      $signed(tlik_pkg::Z_W'(tlik_pkg::atan_tab(STEP)));

   tlik_pkg::cordic_type cell_ff, cell_in_w;
   logic signed [tlik_pkg::CX_W-1:0] xs, ys;

   always_comb begin
      xs = $signed(cell_in.x) >>> STEP;
      ys = $signed(cell_in.y) >>> STEP;
      cell_in_w = cell_in;
      // rotate toward the x axis; y at zero holds
      if ($signed(cell_in.y) > 0) begin
         cell_in_w.x = $signed(cell_in.x) + ys;
         cell_in_w.y = $signed(cell_in.y) - xs;
         cell_in_w.z = $signed(cell_in.z) + ATAN;
      end else if ($signed(cell_in.y) < 0) begin
         cell_in_w.x = $signed(cell_in.x) - ys;
         cell_in_w.y = $signed(cell_in.y) + xs;
         cell_in_w.z = $signed(cell_in.z) - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* src/tlik_joint.sv */
module tlik_joint (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [tlik_pkg::ANG_W-1:0]     angle,
   input  logic signed [tlik_pkg::OFF_W-1:0]     offset,
   output logic [tlik_pkg::JOINT_W-1:0]          joint_out
);

   localparam int AW     = tlik_pkg::ANG_W;
   localparam int PROD_W = AW + 16;
   localparam int R_W    = PROD_W - 32;
   localparam int D_W    = R_W + 2;

   logic [AW-1:0]     mag_ff, mag_in;
   logic              neg1_ff, neg2_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [tlik_pkg::JOINT_W-1:0] out_ff, out_in;
   logic [R_W-1:0]    r;
   logic signed [D_W-1:0] rs, d;
   logic [D_W-1:0]    ad;

   always_comb begin
      mag_in  = angle[AW-1] ? AW'(-angle) : AW'(angle);
      prod_in = PROD_W'(mag_ff) * PROD_W'(tlik_pkg::CENTI_TURN) + PROD_W'(64'h80000000);
      r       = prod_ff[PROD_W-1:32];
      rs      = neg2_ff ? -$signed(D_W'(r)) : $signed(D_W'(r));
      d       = rs - D_W'(offset);
      ad      = d[D_W-1] ? D_W'(-d) : D_W'(d);
      // saturate to the output range
      out_in  = (ad > D_W'(16'hFFFF)) ? 16'hFFFF : ad[tlik_pkg::JOINT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg1_ff <= angle[AW-1];
         prod_ff <= prod_in;
         neg2_ff <= neg1_ff;
         out_ff  <= out_in;
      end
   end

   assign joint_out = out_ff;

endmodule

/* src/two_link_arm_inverse_kinematics.sv */
// channel   dir  handshake        word
// req_ch    in   valid/ready      kind, target_x, target_y
// rsp_ch    out  valid/ready      shoulder_angle, elbow_angle, wrist_angle, status
// csr_*     in   csr_we strobe    csr_index, csr_data
//
// One target enters every cycle unless the chain is held; each passes through the
// 27 square-root cells and the CORDIC_STEPS rotation cells in series.
// Reset is synchronous; it clears the valid bits, output and skid included, and loads the default CSRs.
// A stalled result waits in the output register; a second one goes to a skid
// register, and only then does the whole chain hold and req_ch.ready drop.
module two_link_arm_inverse_kinematics #(
   parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   tlik_req_if.sink                            req_ch,
   tlik_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [tlik_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tlik_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int LW    = tlik_pkg::LEN_W;
   localparam int OW    = tlik_pkg::OFF_W;
   localparam int NW    = tlik_pkg::NXY_W;
   localparam int SQW   = tlik_pkg::SQ_W;
   localparam int DW    = tlik_pkg::DIF2_W;
   localparam int CW    = tlik_pkg::C2_W;
   localparam int XW    = tlik_pkg::N_W;
   localparam int CXW   = tlik_pkg::CX_W;
   localparam int AW    = tlik_pkg::ANG_W;
   localparam int SQ_N  = tlik_pkg::SQRT_STEPS;
   localparam int SCL   = tlik_pkg::SCALE;

   localparam int P_MUL   = SQ_N + 1;
   localparam int P_PRE   = SQ_N + 2;
   localparam int P_SUM   = P_PRE + CORDIC_STEPS + 1;
   localparam int P_TH    = P_SUM + 1;
   localparam int P_J3    = P_TH + 3;
   localparam int DEPTH   = P_J3 + 1;
   localparam int BK_N    = DEPTH - P_PRE;

   // configuration
   logic [LW-1:0] upper_ff, fore_ff, grip_ff, base_ff;
   logic signed [OW-1:0] sh_off_ff, el_off_ff, wr_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= LW'(1000);
         fore_ff   <= LW'(1000);
         grip_ff   <= LW'(500);
         base_ff   <= LW'(500);
         sh_off_ff <= '0;
         el_off_ff <= '0;
         wr_off_ff <= '0;
      end else if (csr_we) begin
         case (tlik_pkg::csr_idx_type'(csr_index))
            tlik_pkg::REG_UPPER_ARM: upper_ff  <= csr_data[LW-1:0];
            tlik_pkg::REG_FOREARM:   fore_ff   <= csr_data[LW-1:0];
            tlik_pkg::REG_GRIPPER:   grip_ff   <= csr_data[LW-1:0];
            tlik_pkg::REG_BASE:      base_ff   <= csr_data[LW-1:0];
            tlik_pkg::REG_SHOULDER:  sh_off_ff <= $signed(csr_data[OW-1:0]);
            tlik_pkg::REG_ELBOW:     el_off_ff <= $signed(csr_data[OW-1:0]);
            tlik_pkg::REG_WRIST:     wr_off_ff <= $signed(csr_data[OW-1:0]);
            default: ;
         endcase
      end
   end

   // chain advance: hold everything only while the skid register is full
   logic en;
   logic skid_v_ff;
   assign en = !skid_v_ff;
   assign req_ch.ready = en;

   // stage 1: wrist point
   logic v1_ff, v2_ff, v3_ff;
   logic k1_ff, k2_ff, k3_ff;
   logic signed [NW-1:0] nx1_ff, ny1_ff, nx2_ff, ny2_ff, nx3_ff, ny3_ff;
   logic signed [NW-1:0] nx_in, ny_in, gs, hs;

   always_comb begin
      gs = $signed(NW'(grip_ff));
      hs = $signed(NW'(base_ff));
      if (req_ch.kind) begin
         nx_in = NW'(req_ch.target_x);
         ny_in = NW'(req_ch.target_y) - hs + gs;
      end else begin
         nx_in = NW'(req_ch.target_x) - gs;
         ny_in = NW'(req_ch.target_y) - hs;
      end
   end

   // stage 2: squares
   logic [SQW-1:0] nxsq_ff, nysq_ff, sum2_ff, sum2b_ff;
   logic [DW-1:0]  dif2_ff, a2_ff, b2_ff, dif2b_ff, a2b_ff, b2b_ff;
   logic signed [2*NW-1:0] nxsq_w, nysq_w;
   logic [LW:0] ab_w;
   logic signed [LW:0] adb_w;
   logic signed [2*LW+1:0] dsq_w;
   logic [2*LW+1:0] absq_w;

   always_comb begin
      nxsq_w = nx1_ff * nx1_ff;
      nysq_w = ny1_ff * ny1_ff;
      ab_w   = (LW+1)'(upper_ff) + (LW+1)'(fore_ff);
      adb_w  = $signed((LW+1)'(upper_ff)) - $signed((LW+1)'(fore_ff));
      absq_w = ab_w * ab_w;
      dsq_w  = adb_w * adb_w;
   end

   // stage 3: c2
   logic [CW-1:0] c2_ff;

   // stage 4 inputs
   tlik_pkg::side_front_type front_in;
   tlik_pkg::sqrt_type sqp_in, sqq_in;
   logic [CW-1:0] p_w, q_w;

   always_comb begin
      p_w = c2_ff - CW'(dif2b_ff);
      q_w = CW'(sum2b_ff) - c2_ff;
      front_in.kind = k3_ff;
      front_in.nx   = nx3_ff;
      front_in.ny   = ny3_ff;
      front_in.n1   = $signed(XW'(a2b_ff)) + $signed(XW'(c2_ff)) - $signed(XW'(b2b_ff));
      front_in.nb   = $signed(XW'(a2b_ff)) + $signed(XW'(b2b_ff)) - $signed(XW'(c2_ff));
      if (c2_ff == '0) begin
         front_in.status = tlik_pkg::STAT_SHOULDER;
      end else if (c2_ff > CW'(sum2b_ff) || c2_ff < CW'(dif2b_ff)) begin
         front_in.status = tlik_pkg::STAT_REACH;
      end else begin
         front_in.status = tlik_pkg::STAT_OK;
      end
      sqp_in.val  = tlik_pkg::SQRT_VAL_W'({p_w, SCL'(0)});
      sqp_in.rem  = '0;
      sqp_in.root = '0;
      sqq_in.val  = tlik_pkg::SQRT_VAL_W'({q_w, SCL'(0)});
      sqq_in.rem  = '0;
      sqq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k1_ff    <= req_ch.kind;
         nx1_ff   <= nx_in;
         ny1_ff   <= ny_in;
         k2_ff    <= k1_ff;
         nx2_ff   <= nx1_ff;
         ny2_ff   <= ny1_ff;
         nxsq_ff  <= nxsq_w[SQW-1:0];
         nysq_ff  <= nysq_w[SQW-1:0];
         sum2_ff  <= absq_w[SQW-1:0];
         dif2_ff  <= dsq_w[DW-1:0];
         a2_ff    <= DW'(upper_ff) * DW'(upper_ff);
         b2_ff    <= DW'(fore_ff) * DW'(fore_ff);
         k3_ff    <= k2_ff;
         nx3_ff   <= nx2_ff;
         ny3_ff   <= ny2_ff;
         c2_ff    <= CW'(nxsq_ff) + CW'(nysq_ff);
         sum2b_ff <= sum2_ff;
         dif2b_ff <= dif2_ff;
         a2b_ff   <= a2_ff;
         b2b_ff   <= b2_ff;
      end
   end

   // valid and sideband lines
   logic vld_ff [DEPTH];
   tlik_pkg::side_front_type front_ff [P_MUL+1];
   tlik_pkg::side_back_type  back_ff  [BK_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= v3_ff;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff[0] <= front_in;
         for (int i = 1; i <= P_MUL; i++) front_ff[i] <= front_ff[i-1];
         back_ff[0].kind   <= front_ff[P_MUL].kind;
         back_ff[0].status <= front_ff[P_MUL].status;
         for (int i = 1; i < BK_N; i++) back_ff[i] <= back_ff[i-1];
      end
   end

   // square roots of p and q
   tlik_pkg::sqrt_type sqp [SQ_N+1];
   tlik_pkg::sqrt_type sqq [SQ_N+1];
   tlik_pkg::sqrt_type sqp0_ff, sqq0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqp0_ff <= sqp_in;
         sqq0_ff <= sqq_in;
      end
   end

   assign sqp[0] = sqp0_ff;
   assign sqq[0] = sqq0_ff;

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      tlik_sqrt_cell u_p (.clock(clock), .en(en), .cell_in(sqp[k]), .cell_out(sqp[k+1]));
      tlik_sqrt_cell u_q (.clock(clock), .en(en), .cell_in(sqq[k]), .cell_out(sqq[k+1]));
   end

   // product of the roots
   logic [tlik_pkg::S_W-1:0] s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= sqp[SQ_N].root * sqq[SQ_N].root;
      end
   end

   // pre-rotation into the right half plane
   function automatic tlik_pkg::cordic_type prerot(input logic signed [CXW-1:0] y,
                                                    input logic signed [CXW-1:0] x);
      tlik_pkg::cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = tlik_pkg::Z_QUARTER;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -tlik_pkg::Z_QUARTER;
         end
      end
      return c;
   endfunction

   tlik_pkg::cordic_type cr_a [CORDIC_STEPS+1];
   tlik_pkg::cordic_type cr_b [CORDIC_STEPS+1];
   tlik_pkg::cordic_type cr_c [CORDIC_STEPS+1];
   tlik_pkg::cordic_type cra0_ff, crb0_ff, crc0_ff;
   logic signed [CXW-1:0] s_w, n1_w, nb_w, nx_w, ny_w;

   always_comb begin
      s_w  = $signed(CXW'(s_ff));
      n1_w = CXW'(front_ff[P_MUL].n1) <<< SCL;
      nb_w = CXW'(front_ff[P_MUL].nb) <<< SCL;
      nx_w = CXW'(front_ff[P_MUL].nx) <<< SCL;
      ny_w = CXW'(front_ff[P_MUL].ny) <<< SCL;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cra0_ff <= prerot(s_w, n1_w);
         crb0_ff <= prerot(ny_w, nx_w);
         crc0_ff <= prerot(s_w, nb_w);
      end
   end

   assign cr_a[0] = cra0_ff;
   assign cr_b[0] = crb0_ff;
   assign cr_c[0] = crc0_ff;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      tlik_cordic_cell #(.STEP(j)) u_a (.clock(clock), .en(en),
                                        .cell_in(cr_a[j]), .cell_out(cr_a[j+1]));
      tlik_cordic_cell #(.STEP(j)) u_b (.clock(clock), .en(en),
                                        .cell_in(cr_b[j]), .cell_out(cr_b[j+1]));
      tlik_cordic_cell #(.STEP(j)) u_c (.clock(clock), .en(en),
                                        .cell_in(cr_c[j]), .cell_out(cr_c[j+1]));
   end

   // joint angles in turn units
   logic signed [AW-1:0] alfa_ff, beta_ff, alfa2_ff, beta2_ff, theta_ff;
   logic signed [AW-1:0] base_w;

   assign base_w = back_ff[P_SUM - P_PRE].kind ? tlik_pkg::ANG_QUARTER
                                               : tlik_pkg::ANG_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         alfa_ff  <= AW'($signed(cr_a[CORDIC_STEPS].z)) + AW'($signed(cr_b[CORDIC_STEPS].z));
         beta_ff  <= AW'($signed(cr_c[CORDIC_STEPS].z));
         alfa2_ff <= alfa_ff;
         beta2_ff <= beta_ff;
         theta_ff <= base_w - alfa_ff - beta_ff;
      end
   end

   logic [tlik_pkg::JOINT_W-1:0] sh_w, el_w, wr_w;

   tlik_joint u_sh (.clock(clock), .en(en), .angle(alfa2_ff), .offset(sh_off_ff),
                    .joint_out(sh_w));
   tlik_joint u_el (.clock(clock), .en(en), .angle(beta2_ff), .offset(el_off_ff),
                    .joint_out(el_w));
   tlik_joint u_wr (.clock(clock), .en(en), .angle(theta_ff), .offset(wr_off_ff),
                    .joint_out(wr_w));

   // result word; error status drops the angles
   tlik_pkg::rsp_word_type pipe_w, out_ff, skid_ff;
   logic out_v_ff, pipe_v;
   tlik_pkg::status_type st_w;

   always_comb begin
      st_w   = back_ff[BK_N-1].status;
      pipe_v = vld_ff[DEPTH-1];
      pipe_w.status = st_w;
      if (st_w == tlik_pkg::STAT_OK) begin
         pipe_w.shoulder_angle = sh_w;
         pipe_w.elbow_angle    = el_w;
         pipe_w.wrist_angle    = wr_w;
      end else begin
         pipe_w.shoulder_angle = '0;
         pipe_w.elbow_angle    = '0;
         pipe_w.wrist_angle    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ch.ready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= pipe_v;
         end
      end else if (pipe_v && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ch.ready) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_w;
      end else if (pipe_v && en) begin
         skid_ff <= pipe_w;
      end
   end

   assign rsp_ch.valid          = out_v_ff;
   assign rsp_ch.shoulder_angle = out_ff.shoulder_angle;
   assign rsp_ch.elbow_angle    = out_ff.elbow_angle;
   assign rsp_ch.wrist_angle    = out_ff.wrist_angle;
   assign rsp_ch.status         = out_ff.status;

endmodule

/* src/tlik_checker.sv */
module tlik_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tlik_pkg::JOINT_W-1:0]  rsp_shoulder,
   input logic [tlik_pkg::JOINT_W-1:0]  rsp_elbow,
   input logic [tlik_pkg::JOINT_W-1:0]  rsp_wrist,
   input logic [tlik_pkg::STAT_W-1:0]   rsp_status
);

   // an error word carries no angles
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tlik_pkg::STAT_OK |->
         rsp_shoulder == '0 && rsp_elbow == '0 && rsp_wrist == '0)
      else $error("error word with nonzero angles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= tlik_pkg::STAT_SHOULDER)
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shoulder) &&
         $stable(rsp_elbow) && $stable(rsp_wrist) && $stable(rsp_status))
      else $error("stalled result word changed");

endmodule

bind two_link_arm_inverse_kinematics tlik_props u_tlik_props (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_shoulder (rsp_ch.shoulder_angle),
   .rsp_elbow    (rsp_ch.elbow_angle),
   .rsp_wrist    (rsp_ch.wrist_angle),
   .rsp_status   (rsp_ch.status)
);

/* sim/tlik_checker.sv */
module tlik_checker (
   input  logic       clock,
   input  logic       reset,
   tlik_req_if        req_ch,
   tlik_rsp_if        rsp_ch,
   input  logic       csr_we,
   input  logic [tlik_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tlik_pkg::CSR_DATA_W-1:0] csr_data,
   output int         fails,
   output int         pending
);
   import tlik_pkg::*;

   localparam longint unsigned ARC_TAB [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

   logic [LEN_W-1:0]        upper_len, fore_len, grip_len, base_len;
   logic signed [OFF_W-1:0] shoulder_off, elbow_off, wrist_off;
   rsp_word_type            joint_q[$];

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, bv;
      r = 0;
      bv = 64'h1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= r + bv) begin
            v = v - (r + bv);
            r = (r >> 1) + bv;
         end else begin
            r = r >> 1;
         end
         bv = bv >> 2;
      end
      return r;
   endfunction

   // vectoring rotation, result in 2^32 per turn
   function automatic longint vec_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sh40000000;
         end else begin
            x = -y; y = t; z = -64'sh40000000;
         end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + longint'(ARC_TAB[i]);
         end else if (y < 0) begin
            x = x - ys; y = y + xs; z = z - longint'(ARC_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic logic [JOINT_W-1:0] joint_value(longint b, logic signed [OFF_W-1:0] off);
      longint unsigned m;
      longint r, d;
      m = (b < 0) ? longint'(-b) : b;
      r = longint'((m * 36000 + (64'h1 << 31)) >> 32);
      if (b < 0) r = -r;
      d = r - longint'(off);
      if (d < 0) d = -d;
      return (d > 65535) ? 16'hFFFF : d[15:0];
   endfunction

   function automatic rsp_word_type solve_target(logic k, logic signed [COORD_W-1:0] tx,
                                                 logic signed [COORD_W-1:0] ty);
      rsp_word_type w;
      longint a, b, g, h, nx, ny, c2, sum2, dif2, s, n1, nb, alfa, beta, theta;
      a = upper_len; b = fore_len; g = grip_len; h = base_len;
      w = '0;
      if (!k) begin
         nx = longint'(tx) - g; ny = longint'(ty) - h;
      end else begin
         nx = tx; ny = longint'(ty) - h + g;
      end
      c2 = nx * nx + ny * ny;
      sum2 = (a + b) * (a + b);
      dif2 = (a - b) * (a - b);
      if (c2 == 0) begin
         w.status = STAT_SHOULDER;
      end else if (c2 > sum2 || c2 < dif2) begin
         w.status = STAT_REACH;
      end else begin
         s = longint'(root_floor((c2 - dif2) << 20) * root_floor((sum2 - c2) << 20));
         n1 = a * a + c2 - b * b;
         nb = a * a + b * b - c2;
         alfa = vec_angle(s, n1 << 20) + vec_angle(ny << 20, nx << 20);
         beta = vec_angle(s, nb << 20);
         theta = (k ? 64'sh40000000 : 64'sh80000000) - (alfa + beta);
         w.shoulder_angle = joint_value(alfa, shoulder_off);
         w.elbow_angle    = joint_value(beta, elbow_off);
         w.wrist_angle    = joint_value(theta, wrist_off);
         w.status         = STAT_OK;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         upper_len <= 1000; fore_len <= 1000; grip_len <= 500; base_len <= 500;
         shoulder_off <= '0; elbow_off <= '0; wrist_off <= '0;
         fails <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_UPPER_ARM: upper_len    <= csr_data[LEN_W-1:0];
               REG_FOREARM:   fore_len     <= csr_data[LEN_W-1:0];
               REG_GRIPPER:   grip_len     <= csr_data[LEN_W-1:0];
               REG_BASE:      base_len     <= csr_data[LEN_W-1:0];
               REG_SHOULDER:  shoulder_off <= csr_data;
               REG_ELBOW:     elbow_off    <= csr_data;
               REG_WRIST:     wrist_off    <= csr_data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            joint_q.push_back(solve_target(req_ch.kind, req_ch.target_x, req_ch.target_y));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (joint_q.size() == 0) begin
               if (fails < 10) $display("unexpected word: %h %h %h %h", rsp_ch.shoulder_angle,
                                        rsp_ch.elbow_angle, rsp_ch.wrist_angle, rsp_ch.status);
               fails <= fails + 1;
            end else begin
               want = joint_q.pop_front();
               if (want.shoulder_angle !== rsp_ch.shoulder_angle ||
                   want.elbow_angle !== rsp_ch.elbow_angle ||
                   want.wrist_angle !== rsp_ch.wrist_angle ||
                   want.status !== rsp_ch.status) begin
                  if (fails < 10)
                     $display("mismatch: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                              want.shoulder_angle, want.elbow_angle, want.wrist_angle,
                              want.status, rsp_ch.shoulder_angle, rsp_ch.elbow_angle,
                              rsp_ch.wrist_angle, rsp_ch.status);
                  fails <= fails + 1;
               end
            end
         end
         pending <= joint_q.size();
      end
   end
endmodule

/* sim/tb_two_link_arm_inverse_kinematics.sv */
module tb_two_link_arm_inverse_kinematics;
   import tlik_pkg::*;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int   fails, pending;
   int   cycle_cnt;
   int   burst_left;
   int   cur_a, cur_b, cur_g, cur_h;

   tlik_req_if req_ch ();
   tlik_rsp_if rsp_ch ();

   two_link_arm_inverse_kinematics u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data));

   tlik_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .fails(fails), .pending(pending));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_cnt = 0;
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt > 400000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver: changing stall patterns, plus long hold-offs to back up the pipe
   initial begin
      int hold, mode, mode_left;
      hold = 0; mode = 0; mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_cnt == 500 || cycle_cnt == 5000) hold = 300;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (mode == 0) rsp_ch.ready <= 1'b1;
         else if (mode == 1) rsp_ch.ready <= ($urandom_range(0, 1) == 1);
         else rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      end
   end

   task automatic csr_write(csr_idx_type idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   // drop the offer, then wait until every word has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic program_arm(int a, int b, int g, int h, int so, int eo, int wo);
      drain();
      csr_write(REG_UPPER_ARM, a);
      csr_write(REG_FOREARM, b);
      csr_write(REG_GRIPPER, g);
      csr_write(REG_BASE, h);
      csr_write(REG_SHOULDER, so);
      csr_write(REG_ELBOW, eo);
      csr_write(REG_WRIST, wo);
      csr_we <= 1'b0;
      cur_a = a; cur_b = b; cur_g = g; cur_h = h;
   endtask

   task automatic send_target(logic k, int x, int y);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.target_x <= x[15:0];
      req_ch.target_y <= y[15:0];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random();
      int r, d, nx, ny, x, y;
      longint c2;
      logic k;
      bit found;
      found = 0;
      k = $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) begin
         r = cur_a + cur_b;
         d = (cur_a > cur_b) ? cur_a - cur_b : cur_b - cur_a;
         for (int t = 0; t < 20 && !found; t++) begin
            if ($urandom_range(0, 15) == 0) begin
               nx = ($urandom_range(0, 1) == 1) ? r : d; ny = 0;
            end else begin
               nx = int'($urandom_range(0, 2 * r)) - r;
               ny = int'($urandom_range(0, 2 * r)) - r;
            end
            c2 = longint'(nx) * nx + longint'(ny) * ny;
            x = k ? nx : nx + cur_g;
            y = k ? ny + cur_h - cur_g : ny + cur_h;
            if (c2 >= longint'(d) * d && c2 <= longint'(r) * r &&
                x >= -32768 && x <= 32767 && y >= -32768 && y <= 32767)
               found = 1;
         end
      end
      if (!found) begin
         x = int'($urandom_range(0, 65535)) - 32768;
         y = int'($urandom_range(0, 65535)) - 32768;
      end
      send_target(k, x, y);
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0; csr_index <= '0; csr_data <= '0;
      req_ch.valid <= 1'b0; req_ch.kind <= 1'b0;
      req_ch.target_x <= '0; req_ch.target_y <= '0;
      burst_left = 0;
      cur_a = 1000; cur_b = 1000; cur_g = 500; cur_h = 500;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: shoulder hits, reach edges, behind shoulder, field extremes
      send_target(0, 500, 500);
      send_target(1, 0, 0);
      send_target(0, 2500, 500);
      send_target(0, 2501, 500);
      send_target(1, 2000, 0);
      send_target(1, 0, 2000);
      send_target(0, -1000, 500);
      send_target(1, -1200, -300);
      send_target(0, 500, -1500);
      send_target(1, -2000, 0);
      send_target(0, 32767, 32767);
      send_target(0, -32768, -32768);
      send_target(1, 32767, -32768);
      send_target(1, -32768, 32767);
      send_target(0, 1500, 1500);
      send_target(1, 1000, -1000);
      send_target(0, 501, 500);
      send_target(1, 0, 1);
      send_target(0, 1914, 1914);
      send_target(1, -1, -1414);
      for (int i = 0; i < 200; i++) send_random();

      program_arm(32767, 32767, 32767, 32767, -36000, -36000, -36000);
      @(posedge clock);
      csr_write(csr_idx_type'(7), 17'h1FFFF);
      csr_we <= 1'b0;
      send_target(0, 32767, 32767);
      send_target(1, 0, 0);
      for (int i = 0; i < 200; i++) send_random();

      program_arm(1, 1, 0, 0, 36000, 36000, 36000);
      send_target(0, 0, 0);
      send_target(0, 2, 0);
      send_target(1, 0, -2);
      for (int i = 0; i < 200; i++) send_random();

      program_arm(1, 32767, 0, 0, 0, 0, 0);
      send_target(0, 32767, 0);
      for (int i = 0; i < 200; i++) send_random();

      for (int p = 0; p < 4; p++) begin
         program_arm($urandom_range(1, 20000), $urandom_range(1, 20000),
                     $urandom_range(0, 32767), $urandom_range(0, 32767),
                     int'($urandom_range(0, 72000)) - 36000,
                     int'($urandom_range(0, 72000)) - 36000,
                     int'($urandom_range(0, 72000)) - 36000);
         for (int i = 0; i < 200; i++) send_random();
      end

      drain();
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
